// File: rtl/xtea_pkg.sv
// Shared types, constants and the mix function for the XTEA encrypt core.
// No dependencies; used by xtea_half_round and xtea_encrypt_block_core.
`timescale 1ns / 1ps

package xtea_pkg;

  localparam int WORD_W    = 32;
  localparam int KEY_COUNT = 4;
  localparam int KEY_IDX_W = 2;

  typedef logic [WORD_W-1:0]                 word_t;
  typedef logic [KEY_COUNT-1:0][WORD_W-1:0]  key_set_t;
  typedef logic [KEY_IDX_W-1:0]              key_idx_t;

  // one block traveling down the pipe
  typedef struct packed {
    logic  valid;
    word_t left;
    word_t right;
  } beat_t;

  localparam word_t DELTA    = 32'h9E3779B9;
  localparam word_t MIX_MASK = 32'h07FFFFFF;

  // configuration register indexes
  localparam key_idx_t KEY_IDX_0 = 2'd0;
  localparam key_idx_t KEY_IDX_1 = 2'd1;
  localparam key_idx_t KEY_IDX_2 = 2'd2;
  localparam key_idx_t KEY_IDX_3 = 2'd3;

  // key reset values
  localparam word_t KEY_RST_0 = 32'h716F7274;
  localparam word_t KEY_RST_1 = 32'h6D64646B;
  localparam word_t KEY_RST_2 = 32'h716F7274;
  localparam word_t KEY_RST_3 = 32'h6D64636B;

  function automatic word_t mix(input word_t v);
    mix = ((v << 4) ^ ((v >> 5) & MIX_MASK)) + v;
  endfunction

endpackage

// File: rtl/xtea_half_round.sv
// One registered XTEA half-round: updates left (first half) or right (second half).
// Depends on xtea_pkg.
`timescale 1ns / 1ps

module xtea_half_round #(
  parameter logic [31:0] SUM    = 32'h0,
  parameter bit          SECOND = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  xtea_pkg::key_set_t keys,
  input  xtea_pkg::beat_t   in_beat,
  output xtea_pkg::beat_t   out_beat
);

  // key word choice is fixed per stage since sum is
  localparam xtea_pkg::key_idx_t KEY_SEL = SECOND ? SUM[12:11] : SUM[1:0];

  xtea_pkg::word_t key_term;
  xtea_pkg::word_t left_next;
  xtea_pkg::word_t right_next;

  always_comb begin
    key_term   = keys[KEY_SEL] + SUM;
    left_next  = in_beat.left;
    right_next = in_beat.right;
    if (SECOND) begin
      right_next = in_beat.right + (xtea_pkg::mix(in_beat.left) ^ key_term);
    end else begin
      left_next  = in_beat.left + (xtea_pkg::mix(in_beat.right) ^ key_term);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat.valid <= 1'b0;
    end else begin
      out_beat.valid <= in_beat.valid;
    end
    out_beat.left  <= left_next;
    out_beat.right <= right_next;
  end

endmodule

// File: rtl/xtea_encrypt_block_core.sv
// Top level of the XTEA encrypt core: key registers, start/busy intake, half-round pipe.
// Depends on xtea_pkg and xtea_half_round.
`timescale 1ns / 1ps

// XTEA block encryption, one 64-bit block per beat, fully pipelined.
// A beat is taken on every rising edge with start high and busy low; busy is
// high only for the cycle after reset, so after that one block can enter every
// cycle. Each half-round is one register stage, so a block runs through all
// 2*ROUNDS register stages before it comes out on cipher_left/cipher_right,
// and done is high for a single cycle as that block comes out. The
// receiver cannot stall the pipe: a result not taken in its cycle is gone.
// The 128-bit key sits in four 32-bit registers written through cfg_write /
// cfg_index / cfg_data; they reset to the built-in key. Change the key only
// with the pipe empty, since every stage reads the live key registers.
module xtea_encrypt_block_core #(
  parameter int ROUNDS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  // block intake
  input  logic                    start,
  output logic                    busy,
  input  logic [31:0]             plain_left,
  input  logic [31:0]             plain_right,
  // results
  output logic                    done,
  output logic [31:0]             cipher_left,
  output logic [31:0]             cipher_right,
  // key configuration
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data
);

  // two half-rounds per round, one stage each
  localparam int STAGES = 2 * ROUNDS;

  xtea_pkg::key_set_t keys;
  xtea_pkg::beat_t    pipe [0:STAGES];
  logic               accept;

  // intake is closed only in the cycle after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  always_comb begin
    pipe[0].valid = accept;
    pipe[0].left  = plain_left;
    pipe[0].right = plain_right;
  end

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      keys[xtea_pkg::KEY_IDX_0] <= xtea_pkg::KEY_RST_0;
      keys[xtea_pkg::KEY_IDX_1] <= xtea_pkg::KEY_RST_1;
      keys[xtea_pkg::KEY_IDX_2] <= xtea_pkg::KEY_RST_2;
      keys[xtea_pkg::KEY_IDX_3] <= xtea_pkg::KEY_RST_3;
    end else if (cfg_write) begin
      case (cfg_index)
        xtea_pkg::KEY_IDX_0: keys[xtea_pkg::KEY_IDX_0] <= cfg_data;
        xtea_pkg::KEY_IDX_1: keys[xtea_pkg::KEY_IDX_1] <= cfg_data;
        xtea_pkg::KEY_IDX_2: keys[xtea_pkg::KEY_IDX_2] <= cfg_data;
        xtea_pkg::KEY_IDX_3: keys[xtea_pkg::KEY_IDX_3] <= cfg_data;
        default: keys <= keys;
      endcase
    end
  end

  // Stage g is half (g % 2) of round g / 2. The first half uses sum = round*delta,
  // the second half the already advanced sum = (round+1)*delta; both are
  // elaboration constants, so no sum register travels with the block.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    localparam logic [31:0] STAGE_SUM = 32'(g / 2 + g % 2) * xtea_pkg::DELTA;

    xtea_half_round #(
      .SUM    (STAGE_SUM),
      .SECOND (bit'(g % 2))
    ) u_half (
      .clk      (clk),
      .rst      (rst),
      .keys     (keys),
      .in_beat  (pipe[g]),
      .out_beat (pipe[g+1])
    );
  end

  assign done         = pipe[STAGES].valid;
  assign cipher_left  = pipe[STAGES].left;
  assign cipher_right = pipe[STAGES].right;

  // every accepted block comes out with done after passing all STAGES stages
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##STAGES done)
    else $error("accepted block did not emerge after pipeline latency");

  // no result without a matching intake
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, STAGES))
    else $error("result without a block accepted at pipeline depth");

  // intake is closed right after reset
  a_busy_after_rst: assert property (@(posedge clk)
    rst |=> busy && !done)
    else $error("intake open or result present right after reset");

endmodule
